// File: design/radar_jacobian_top_defines.svh
// ----------------------------------------------------------------------------
// Radar Jacobian assertion macros
// Shared assertion forms for the radar Jacobian block, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RADAR_JACOBIAN_TOP_DEFINES_SVH
`define RADAR_JACOBIAN_TOP_DEFINES_SVH

// Implication: whenever ante holds, cons must hold from that edge.
`define RJ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The expression must never be true.
`define RJ_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// File: design/rj_pkg.sv
// ----------------------------------------------------------------------------
// Radar Jacobian package
// Word formats, cell types and pipeline depths shared by the cells and the
// top level of the radar Jacobian block.
// ----------------------------------------------------------------------------
package rj_pkg;

	// Fixed-point format of every field
	localparam int WORD_W = 32;
	localparam int FRAC_W = 16;
	localparam int CFG_W  = 31;

	// Square root: one result bit per cell, two radicand bits consumed per cell
	localparam int SQ_W       = 2 * WORD_W;
	localparam int SQRT_STEPS = WORD_W;
	localparam int SQ_REM_W   = WORD_W + 3;

	// Division: one quotient bit per cell
	localparam int DIV_STEPS = WORD_W + FRAC_W;
	localparam int DIV_REM_W = SQ_W + 1;
	localparam int NUM_W     = SQ_W + FRAC_W + 1;
	localparam int NUM_LANES = 5;

	// Edges from request acceptance to the result strobe being sampled
	localparam int LATENCY = 3 + SQRT_STEPS + 1 + DIV_STEPS + 2;

	// One square-root cell's state
	typedef struct packed {
		logic [SQ_REM_W-1:0] rem;
		logic [WORD_W-1:0]   root;
		logic [SQ_W-1:0]     rad;
	} sq_cell_t;

	// One division lane's state
	typedef struct packed {
		logic [DIV_REM_W-1:0] rem;
		logic [DIV_STEPS-1:0] num;
		logic [DIV_STEPS-1:0] quo;
		logic [SQ_W-1:0]      dvs;
	} dv_lane_t;

endpackage

// File: design/rj_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Radar Jacobian square-root cell
// One digit-by-digit step of an integer square root: brings in two radicand
// bits, settles one root bit and registers the result for the next cell.
// ----------------------------------------------------------------------------
module rj_sqrt_cell (
	input  logic              clk,
	input  rj_pkg::sq_cell_t  d,
	output rj_pkg::sq_cell_t  q
);

	logic [rj_pkg::SQ_REM_W-1:0] cand;
	logic [rj_pkg::SQ_REM_W-1:0] trial;
	logic                        ge;

	// Trial subtraction of (4 * root + 1) from the extended remainder.
	always_comb begin
		cand  = {d.rem[rj_pkg::SQ_REM_W-3:0], d.rad[rj_pkg::SQ_W-1 -: 2]};
		trial = {1'b0, d.root, 2'b01};
		ge    = (cand >= trial);
	end

	// Hand the updated state to the next cell.
	always_ff @(posedge clk) begin
		q.rem  <= ge ? (cand - trial) : cand;
		q.root <= {d.root[rj_pkg::WORD_W-2:0], ge};
		q.rad  <= {d.rad[rj_pkg::SQ_W-3:0], 2'b00};
	end

endmodule

// File: design/rj_div_cell.sv
// ----------------------------------------------------------------------------
// Radar Jacobian division cell
// One restoring division step: shifts in the next numerator bit, settles one
// quotient bit and registers the lane for the next cell.
// ----------------------------------------------------------------------------
module rj_div_cell (
	input  logic              clk,
	input  rj_pkg::dv_lane_t  d,
	output rj_pkg::dv_lane_t  q
);

	logic [rj_pkg::DIV_REM_W-1:0] cand;
	logic                         ge;

	// Compare the shifted remainder with the divisor.
	always_comb begin
		cand = {d.rem[rj_pkg::DIV_REM_W-2:0], d.num[rj_pkg::DIV_STEPS-1]};
		ge   = (cand >= {1'b0, d.dvs});
	end

	// Hand the updated lane to the next cell.
	always_ff @(posedge clk) begin
		q.rem <= ge ? (cand - {1'b0, d.dvs}) : cand;
		q.num <= {d.num[rj_pkg::DIV_STEPS-2:0], 1'b0};
		q.quo <= {d.quo[rj_pkg::DIV_STEPS-2:0], ge};
		q.dvs <= d.dvs;
	end

endmodule

// File: design/radar_jacobian_top.sv
// ----------------------------------------------------------------------------
// Radar Jacobian top level
// Computes the distinct entries of the radar measurement Jacobian from one
// Q16.16 state vector per request, through a row of square-root cells and a
// row of division cells.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  request   in         start, busy          pos_x, pos_y, vel_x, vel_y
//  result    out        done (one cycle)     range_*, bearing_*, rate_*, singular
//  config    in         cfg_valid, cfg_ready cfg_data (min_range_sq)
//
// A request is accepted every cycle; busy is never raised.
// Each result passes through the 32 square-root cells and the 48 division
// cells in series, plus front and back stages.
// The receiver cannot stall; results are strobed by done for one cycle.
// Reset clears the pipeline valid bits and sets min_range_sq to 7.
// ----------------------------------------------------------------------------
`include "radar_jacobian_top_defines.svh"

module radar_jacobian_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [rj_pkg::WORD_W-1:0]    pos_x,
	input  logic signed [rj_pkg::WORD_W-1:0]    pos_y,
	input  logic signed [rj_pkg::WORD_W-1:0]    vel_x,
	input  logic signed [rj_pkg::WORD_W-1:0]    vel_y,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rj_pkg::CFG_W-1:0]            cfg_data,
	output logic                                done,
	output logic signed [rj_pkg::WORD_W-1:0]    range_dpx,
	output logic signed [rj_pkg::WORD_W-1:0]    range_dpy,
	output logic signed [rj_pkg::WORD_W-1:0]    bearing_dpx,
	output logic signed [rj_pkg::WORD_W-1:0]    bearing_dpy,
	output logic signed [rj_pkg::WORD_W-1:0]    rate_dpx,
	output logic signed [rj_pkg::WORD_W-1:0]    rate_dpy,
	output logic                                singular
);

	localparam int W     = rj_pkg::WORD_W;
	localparam int SW    = rj_pkg::SQ_W;
	localparam int NSQ   = rj_pkg::SQRT_STEPS;
	localparam int NDV   = rj_pkg::DIV_STEPS;
	localparam int NL    = rj_pkg::NUM_LANES;
	localparam int MAG_W = NDV + 1;
	localparam int PRD_W = NDV + rj_pkg::FRAC_W + 1;

	// Division lanes
	localparam int LN_RDX  = 0;
	localparam int LN_RDY  = 1;
	localparam int LN_BDX  = 2;
	localparam int LN_BDY  = 3;
	localparam int LN_RATE = 4;

	// Values riding alongside the square-root cells
	typedef struct packed {
		logic          sing;
		logic          xn;
		logic          yn;
		logic          dn;
		logic [W-1:0]  xm;
		logic [W-1:0]  ym;
		logic [SW-1:0] s;
		logic [SW-1:0] dm;
	} side_t;

	// Values riding alongside the division cells
	typedef struct packed {
		logic          sing;
		logic          xn;
		logic          yn;
		logic          dn;
		logic [NL-1:0] ovf;
	} flag_t;

	// Saturate a magnitude to the signed word and apply the sign.
	function automatic logic [W-1:0] sat_pack(input logic neg, input logic big,
			input logic [MAG_W-1:0] mag);
		logic [MAG_W-1:0] lim;
		logic [W-1:0]     m;
		lim = (MAG_W'(1) << (W - 1)) - MAG_W'(!neg);
		m   = (big || (mag > lim)) ? lim[W-1:0] : mag[W-1:0];
		return neg ? (W'(0) - m) : m;
	endfunction

	logic [rj_pkg::CFG_W-1:0] min_range_sq_q;

	logic          v_s1, v_s2, v_s3;
	logic          xn_s1, yn_s1, vxn_s1, vyn_s1;
	logic [W-1:0]  xm_s1, ym_s1, vxm_s1, vym_s1;
	logic          xn_s2, yn_s2, an_s2, bn_s2;
	logic [W-1:0]  xm_s2, ym_s2;
	logic [SW-1:0] xx_s2, yy_s2, a_s2, b_s2;
	logic          xn_s3, yn_s3, dn_s3;
	logic [W-1:0]  xm_s3, ym_s3;
	logic [SW-1:0] s_s3, dm_s3;
	logic [SW-1:0] dm_d;
	logic          dn_d;
	logic [SW:0]   diff_d;

	rj_pkg::sq_cell_t sq_init;
	rj_pkg::sq_cell_t sq_link [NSQ];
	side_t            side_in;
	side_t            side_q  [NSQ];
	logic [NSQ-1:0]   vld_sq_q;

	logic [rj_pkg::NUM_W-1:0] numer [NL];
	logic [SW-1:0]            dvsr  [NL];
	rj_pkg::dv_lane_t         dv_init_s4 [NL];
	rj_pkg::dv_lane_t         dv_link    [NL][NDV];
	flag_t                    flag_s4;
	flag_t                    flag_q [NDV];
	logic                     v_s4;
	logic [NDV-1:0]           vld_dv_q;

	rj_pkg::dv_lane_t lane_o [NL];
	flag_t            fo;
	logic             v_s5;
	flag_t            flag_s5;
	logic [W-1:0]     rdx_s5, rdy_s5, bdx_s5, bdy_s5;
	logic [PRD_W-1:0] prd_x_s5, prd_y_s5;
	logic             big_x_s5, big_y_s5;

	logic             v_s6, sing_s6;
	logic [W-1:0]     rdx_s6, rdy_s6, bdx_s6, bdy_s6, tdx_s6, tdy_s6;

	// Handshakes: a request and a configuration write are taken every cycle.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_sq_q <= rj_pkg::CFG_W'(7);
		end else if (cfg_valid && cfg_ready) begin
			min_range_sq_q <= cfg_data;
		end
	end

	// Front valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: split the inputs into sign and magnitude.
	always_ff @(posedge clk) begin
		xn_s1  <= pos_x[W-1];
		yn_s1  <= pos_y[W-1];
		vxn_s1 <= vel_x[W-1];
		vyn_s1 <= vel_y[W-1];
		xm_s1  <= pos_x[W-1] ? W'(-pos_x) : W'(pos_x);
		ym_s1  <= pos_y[W-1] ? W'(-pos_y) : W'(pos_y);
		vxm_s1 <= vel_x[W-1] ? W'(-vel_x) : W'(vel_x);
		vym_s1 <= vel_y[W-1] ? W'(-vel_y) : W'(vel_y);
	end

	// Stage 2: the four exact products.
	always_ff @(posedge clk) begin
		xx_s2 <= SW'(xm_s1) * SW'(xm_s1);
		yy_s2 <= SW'(ym_s1) * SW'(ym_s1);
		a_s2  <= SW'(vxm_s1) * SW'(ym_s1);
		b_s2  <= SW'(vym_s1) * SW'(xm_s1);
		an_s2 <= vxn_s1 ^ yn_s1;
		bn_s2 <= vyn_s1 ^ xn_s1;
		xn_s2 <= xn_s1;
		yn_s2 <= yn_s1;
		xm_s2 <= xm_s1;
		ym_s2 <= ym_s1;
	end

	// Cross term vx*py - vy*px as sign and magnitude.
	always_comb begin
		diff_d = {1'b0, a_s2} - {1'b0, b_s2};
		if (an_s2 != bn_s2) begin
			dm_d = a_s2 + b_s2;
			dn_d = an_s2;
		end else if (!diff_d[SW]) begin
			dm_d = diff_d[SW-1:0];
			dn_d = an_s2;
		end else begin
			dm_d = SW'(0) - diff_d[SW-1:0];
			dn_d = !an_s2;
		end
	end

	// Stage 3: squared range and cross term.
	always_ff @(posedge clk) begin
		s_s3  <= xx_s2 + yy_s2;
		dm_s3 <= dm_d;
		dn_s3 <= dn_d;
		xn_s3 <= xn_s2;
		yn_s3 <= yn_s2;
		xm_s3 <= xm_s2;
		ym_s3 <= ym_s2;
	end

	// Entry into the square-root row, with the singular test.
	always_comb begin
		sq_init.rem  = '0;
		sq_init.root = '0;
		sq_init.rad  = s_s3;
		side_in.sing = (s_s3 == '0) ||
			(s_s3 < {{(SW - rj_pkg::CFG_W - rj_pkg::FRAC_W){1'b0}}, min_range_sq_q,
				{rj_pkg::FRAC_W{1'b0}}});
		side_in.xn   = xn_s3;
		side_in.yn   = yn_s3;
		side_in.dn   = dn_s3;
		side_in.xm   = xm_s3;
		side_in.ym   = ym_s3;
		side_in.s    = s_s3;
		side_in.dm   = dm_s3;
	end

	// Square-root row with its side line.
	for (genvar k = 0; k < NSQ; k++) begin : g_sq
		if (k == 0) begin : g_first
			rj_sqrt_cell u_cell (.clk(clk), .d(sq_init), .q(sq_link[k]));
			always_ff @(posedge clk) begin
				side_q[k] <= side_in;
			end
		end else begin : g_rest
			rj_sqrt_cell u_cell (.clk(clk), .d(sq_link[k-1]), .q(sq_link[k]));
			always_ff @(posedge clk) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sq_q <= '0;
		end else begin
			vld_sq_q <= {vld_sq_q[NSQ-2:0], v_s3};
		end
	end

	// Numerators and divisors of the five division lanes.
	always_comb begin
		numer[LN_RDX]  = rj_pkg::NUM_W'({side_q[NSQ-1].xm, {rj_pkg::FRAC_W{1'b0}}});
		numer[LN_RDY]  = rj_pkg::NUM_W'({side_q[NSQ-1].ym, {rj_pkg::FRAC_W{1'b0}}});
		numer[LN_BDX]  = rj_pkg::NUM_W'({side_q[NSQ-1].ym, {(2*rj_pkg::FRAC_W){1'b0}}});
		numer[LN_BDY]  = rj_pkg::NUM_W'({side_q[NSQ-1].xm, {(2*rj_pkg::FRAC_W){1'b0}}});
		numer[LN_RATE] = rj_pkg::NUM_W'({side_q[NSQ-1].dm, {rj_pkg::FRAC_W{1'b0}}});
		dvsr[LN_RDX]   = SW'(sq_link[NSQ-1].root);
		dvsr[LN_RDY]   = SW'(sq_link[NSQ-1].root);
		dvsr[LN_BDX]   = side_q[NSQ-1].s;
		dvsr[LN_BDY]   = side_q[NSQ-1].s;
		dvsr[LN_RATE]  = side_q[NSQ-1].s;
	end

	// Stage 4: load the lanes; high quotient bits beyond the row flag overflow.
	always_ff @(posedge clk) begin
		for (int l = 0; l < NL; l++) begin
			dv_init_s4[l].rem <= rj_pkg::DIV_REM_W'(numer[l][rj_pkg::NUM_W-1:NDV]);
			dv_init_s4[l].num <= numer[l][NDV-1:0];
			dv_init_s4[l].quo <= '0;
			dv_init_s4[l].dvs <= dvsr[l];
			flag_s4.ovf[l]    <= rj_pkg::DIV_REM_W'(numer[l][rj_pkg::NUM_W-1:NDV]) >=
				{1'b0, dvsr[l]};
		end
		flag_s4.sing <= side_q[NSQ-1].sing;
		flag_s4.xn   <= side_q[NSQ-1].xn;
		flag_s4.yn   <= side_q[NSQ-1].yn;
		flag_s4.dn   <= side_q[NSQ-1].dn;
	end

	// Division rows, one per lane.
	for (genvar l = 0; l < NL; l++) begin : g_lane
		for (genvar k = 0; k < NDV; k++) begin : g_dv
			if (k == 0) begin : g_first
				rj_div_cell u_cell (.clk(clk), .d(dv_init_s4[l]), .q(dv_link[l][k]));
			end else begin : g_rest
				rj_div_cell u_cell (.clk(clk), .d(dv_link[l][k-1]), .q(dv_link[l][k]));
			end
		end
	end

	// Flag line alongside the division rows.
	for (genvar k = 0; k < NDV; k++) begin : g_flag
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				flag_q[k] <= flag_s4;
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				flag_q[k] <= flag_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4     <= 1'b0;
			vld_dv_q <= '0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
		end else begin
			v_s4     <= vld_sq_q[NSQ-1];
			vld_dv_q <= {vld_dv_q[NDV-2:0], v_s4};
			v_s5     <= vld_dv_q[NDV-1];
			v_s6     <= v_s5;
		end
	end

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			lane_o[l] = dv_link[l][NDV-1];
		end
		fo = flag_q[NDV-1];
	end

	// Stage 5: saturate the quotients and form the range-rate products.
	always_ff @(posedge clk) begin
		flag_s5  <= fo;
		rdx_s5   <= sat_pack(fo.xn, fo.ovf[LN_RDX], MAG_W'(lane_o[LN_RDX].quo));
		rdy_s5   <= sat_pack(fo.yn, fo.ovf[LN_RDY], MAG_W'(lane_o[LN_RDY].quo));
		bdx_s5   <= sat_pack(!fo.yn, fo.ovf[LN_BDX], MAG_W'(lane_o[LN_BDX].quo));
		bdy_s5   <= sat_pack(fo.xn, fo.ovf[LN_BDY], MAG_W'(lane_o[LN_BDY].quo));
		prd_x_s5 <= PRD_W'(lane_o[LN_RATE].quo) *
			PRD_W'(lane_o[LN_RDY].quo[rj_pkg::FRAC_W:0]);
		prd_y_s5 <= PRD_W'(lane_o[LN_RATE].quo) *
			PRD_W'(lane_o[LN_RDX].quo[rj_pkg::FRAC_W:0]);
		big_x_s5 <= fo.ovf[LN_RATE] && (lane_o[LN_RDY].quo[rj_pkg::FRAC_W:0] != '0);
		big_y_s5 <= fo.ovf[LN_RATE] && (lane_o[LN_RDX].quo[rj_pkg::FRAC_W:0] != '0);
	end

	// Stage 6: range-rate terms and clearing of singular results.
	always_ff @(posedge clk) begin
		sing_s6 <= flag_s5.sing;
		if (flag_s5.sing) begin
			rdx_s6 <= '0;
			rdy_s6 <= '0;
			bdx_s6 <= '0;
			bdy_s6 <= '0;
			tdx_s6 <= '0;
			tdy_s6 <= '0;
		end else begin
			rdx_s6 <= rdx_s5;
			rdy_s6 <= rdy_s5;
			bdx_s6 <= bdx_s5;
			bdy_s6 <= bdy_s5;
			tdx_s6 <= sat_pack(flag_s5.yn ^ flag_s5.dn, big_x_s5,
				prd_x_s5[PRD_W-1:rj_pkg::FRAC_W]);
			tdy_s6 <= sat_pack(flag_s5.xn == flag_s5.dn, big_y_s5,
				prd_y_s5[PRD_W-1:rj_pkg::FRAC_W]);
		end
	end

	// Result ports.
	assign done        = v_s6;
	assign singular    = sing_s6;
	assign range_dpx   = rdx_s6;
	assign range_dpy   = rdy_s6;
	assign bearing_dpx = bdx_s6;
	assign bearing_dpy = bdy_s6;
	assign rate_dpx    = tdx_s6;
	assign rate_dpy    = tdy_s6;

	// Checks on the pipeline.
	`RJ_ASSERT_IMP(a_latency, start && !busy, ##(rj_pkg::LATENCY) done,
		"result strobe missing after a request")
	`RJ_ASSERT_NEVER(a_sing_zero, done && singular && ((range_dpx != 0) ||
		(range_dpy != 0) || (bearing_dpx != 0) || (bearing_dpy != 0) ||
		(rate_dpx != 0) || (rate_dpy != 0)), "singular result with non-zero entries")
	`RJ_ASSERT_IMP(a_unit_range, done && !singular,
		(range_dpx <= 65536) && (range_dpx >= -65536) &&
		(range_dpy <= 65536) && (range_dpy >= -65536),
		"range direction term exceeds one")

endmodule
